/* design/rmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg: shared definitions for the running mean filter
// Sample width, default window length and the divider status bundle.
// ----------------------------------------------------------------------------
package rmf_pkg;

  // Width of one sample and one result
  localparam int SAMPLE_W   = 16;

  // Default number of samples in the averaging window
  localparam int RMF_WINDOW = 32;

  // Status of the serial divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/rmf_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_ring: sample ring storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rmf_ring #(
  parameter int DEPTH  = rmf_pkg::RMF_WINDOW,
  parameter int ADDR_W = (rmf_pkg::RMF_WINDOW > 1) ? $clog2(rmf_pkg::RMF_WINDOW) : 1,
  parameter int DATA_W = rmf_pkg::SAMPLE_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  import rmf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write the new sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read of the oldest entry
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/rmf_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_divider: serial restoring divider
// Unsigned magnitude divided by the fill count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmf_divider #(
  parameter int MAG_W = rmf_pkg::SAMPLE_W + $clog2(rmf_pkg::RMF_WINDOW + 1),
  parameter int DEN_W = $clog2(rmf_pkg::RMF_WINDOW + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MAG_W-1:0]    dividend,
  input  logic [DEN_W-1:0]    divisor,
  output logic [MAG_W-1:0]    quotient,
  output rmf_pkg::div_stat_t  stat
);
  import rmf_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);

  logic [MAG_W-1:0]  quot_r, quot_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    rem_diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_shift = {rem_r, quot_r[MAG_W-1]};
    rem_diff  = rem_shift - {1'b0, den_r};
    fits      = (rem_shift >= {1'b0, den_r});
    rem_nxt   = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    quot_nxt  = {quot_r[MAG_W-2:0], fits};
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(MAG_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      den_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign quotient  = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* design/running_mean_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_filter: moving average over the last WINDOW signed samples
// Filter mode: an item passes the read, update, divider start, divider wait
// and done states from accept to result; the wait lasts until the serial divider finishes.
// Pass-through mode: the accepted sample goes straight to the done state.
// One item at a time: a new item is taken only after the current result
// is loaded into the output register; in_stall holds until then.
// Synchronous active-low reset clears sum, slot, count and enables filtering.
// ----------------------------------------------------------------------------
module running_mean_filter #(
  parameter int WINDOW = rmf_pkg::RMF_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmf_pkg::SAMPLE_W-1:0] out_average,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_filter_enable
);
  import rmf_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W + 1;
  localparam int MAG_W  = SUM_W - 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_START = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       enable_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic signed [SAMPLE_W-1:0] result_r, result_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_average_r;

  logic                       in_take;
  logic                       out_load;
  logic                       full;
  logic signed [SAMPLE_W-1:0] ring_rdata;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    sum_abs;
  logic [MAG_W-1:0]           div_quot;
  div_stat_t                  div_stat;
  logic [SAMPLE_W-1:0]        quot_low;

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign full      = (count_r == CNT_W'(WINDOW));

  // During warm-up the slot being overwritten was never written: treat as zero
  assign old_sample = full ? ring_rdata : '0;

  rmf_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W),
    .DATA_W (SAMPLE_W)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == ST_UPD),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  // Magnitude of the running sum for the unsigned divider
  assign sum_abs = sum_r[SUM_W-1] ? -sum_r : sum_r;

  rmf_divider #(
    .MAG_W (MAG_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .dividend (sum_abs[MAG_W-1:0]),
    .divisor  (count_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  assign quot_low = div_quot[SAMPLE_W-1:0];

  // Sequencer and datapath next values
  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    result_nxt = result_r;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (enable_r) begin
            state_nxt = ST_READ;
          end else begin
            result_nxt = in_sample;
            state_nxt  = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        sum_nxt   = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
        count_nxt = full ? count_r : count_r + 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          result_nxt = sum_r[SUM_W-1] ? SAMPLE_W'(~quot_low + 1'b1) : quot_low;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: hold while stalled, drop once taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b1;
      sum_r       <= '0;
      slot_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_filter_enable;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r <= in_sample;
    end
    result_r <= result_nxt;
    if (out_load) begin
      out_average_r <= result_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // Fill count never passes the window length
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW))
    else $error("fill count above window length");

  // During warm-up the write slot tracks the fill count
  assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> ({1'b0, slot_r} == (SLOT_W + 1)'(count_r)))
    else $error("write slot out of step with fill count");

  // Divider completes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_WAIT))
    else $error("divider finished outside the wait state");

  // Divider runs only after a start issued by the sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_stat.busy) |-> ($past(state_r) == ST_START))
    else $error("divider started without a start state");

endmodule

/* verif/tb_running_mean_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_mean_filter: self-checking bench for the running mean filter
// Drives signed samples through the valid/stall input and tracks the window,
// running sum and fill count in a local copy. Every result is compared in
// order against the predicted mean, or against the raw sample in pass-through.
// Covers warm-up, pass-through switching, random traffic and output back-pressure.
// ----------------------------------------------------------------------------
module tb_running_mean_filter;
  import rmf_pkg::*;

  localparam logic FILTER_OFF = 1'b0;
  localparam logic FILTER_ON  = 1'b1;

  typedef enum int {
    BURST_NOISE,
    BURST_RAIL,
    BURST_NEAR_ZERO,
    BURST_LEVEL
  } burst_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_filter_enable = 1'b0;

  // Local copy of the filter state
  logic signed [SAMPLE_W-1:0] window_ring [RMF_WINDOW];
  int window_total;
  int unsigned next_slot;
  int unsigned samples_held;
  logic model_filter_on;

  logic signed [SAMPLE_W-1:0] expected_means [$];

  int err_count = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  running_mean_filter DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_average       (out_average),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_filter_enable (cfg_filter_enable)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Clear the local window state
  function automatic void clear_window();
    for (int i = 0; i < RMF_WINDOW; i++) window_ring[i] = '0;
    window_total = 0;
    next_slot = 0;
    samples_held = 0;
    model_filter_on = FILTER_ON;
  endfunction

  // Advance the window with one sample and return the expected result
  function automatic logic signed [SAMPLE_W-1:0] predict_mean(
    input logic signed [SAMPLE_W-1:0] s
  );
    int mean;
    if (model_filter_on == FILTER_OFF) return s;
    window_total = window_total - int'(window_ring[next_slot]) + int'(s);
    window_ring[next_slot] = s;
    next_slot = (next_slot + 1) % RMF_WINDOW;
    if (samples_held < RMF_WINDOW) samples_held++;
    // integer division truncates toward zero
    mean = window_total / int'(samples_held);
    return mean[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // Idle for random cycles, then offer one sample and hold it until accepted
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_means.push_back(predict_mean(s));
  endtask

  // Drain pending results, then write the enable register
  task automatic write_filter_enable(input logic en);
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_filter_enable <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_filter_on = en;
  endtask

  // Drive the result stall: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_average));
      end else begin
        want = expected_means.pop_front();
        if (out_average !== want)
          report_mismatch($sformatf("average got %0d expected %0d", out_average, want));
      end
    end
  end

  // Warm-up from reset: extremes, negatives and truncation toward zero
  task automatic test_warmup();
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd1);
    send_sample(-16'sd2);
    send_sample(-16'sd3);
    send_sample(16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd21845);
    send_sample(-16'sd21846);
  endtask

  // Pass-through mode, then confirm the window survives the switch
  task automatic test_passthrough();
    write_filter_enable(FILTER_OFF);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd12345);
    write_filter_enable(FILTER_ON);
    send_sample(-16'sd7);
    send_sample(16'sd100);
  endtask

  // Bursts of related samples so the window reaches full-rail sums
  task automatic send_bursts(input int count);
    burst_kind_t kind;
    int len;
    int sent;
    logic signed [SAMPLE_W-1:0] level;
    logic signed [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < count) begin
      kind  = burst_kind_t'($urandom_range(0, 3));
      len   = $urandom_range(8, 48);
      level = SAMPLE_W'($urandom);
      for (int j = 0; j < len && sent < count; j++) begin
        case (kind)
          BURST_NOISE: begin
            s = SAMPLE_W'($urandom);
          end
          BURST_RAIL: begin
            if ($urandom_range(0, 9) == 0) s = SAMPLE_W'($urandom);
            else s = level[SAMPLE_W-1] ? -16'sd32768 : 16'sd32767;
          end
          BURST_NEAR_ZERO: begin
            s = $signed(16'($urandom_range(0, 16))) - 16'sd8;
          end
          default: begin
            s = level ^ 16'($urandom_range(0, 7));
          end
        endcase
        send_sample(s);
        sent++;
      end
    end
  endtask

  // Random traffic under one idling setting, with mode switches in between
  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    write_filter_enable(FILTER_ON);
    send_bursts(60);
    write_filter_enable(FILTER_OFF);
    send_bursts(30);
    write_filter_enable(FILTER_ON);
    send_bursts(60);
    in_valid <= 1'b0;
  endtask

  // Hold the result side off while the sender keeps offering samples
  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_request = 200;
    for (int i = 0; i < 12; i++) send_sample(SAMPLE_W'($urandom));
    in_valid <= 1'b0;
    while (hold_left != 0 || expected_means.size() != 0) @(posedge clk);
  endtask

  initial begin
    clear_window();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_warmup();
    test_passthrough();
    test_random_traffic(26, 84);
    test_random_traffic(84, 26);
    test_random_traffic(0, 0);
    test_backpressure();

    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
